// ----- rtl/qte_pkg.sv -----
// Package for the quaternion to Euler angle core.
// Holds the sideband structs, fixed-point constants and helper functions.
// No dependencies.
package qte_pkg;

  localparam int OutLimit = 23040;
  localparam logic [39:0] OneQ30 = 40'd1 << 30;
  localparam logic signed [25:0] Deg90Q16 = 26'sd5898240;

  // Operands carried alongside the first square root.
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [32:0] sx;
    logic [32:0] sy;
    logic [32:0] sz;
  } qte_vec_side_t;

  // Angle arguments carried alongside the pitch square root.
  typedef struct packed {
    logic signed [39:0] sinr;
    logic signed [39:0] cosr;
    logic signed [39:0] siny;
    logic signed [39:0] cosy;
    logic signed [39:0] sinp;
    logic sat_pos;
    logic sat_neg;
  } qte_ang_side_t;

  typedef struct packed {
    logic sat_pos;
    logic sat_neg;
  } qte_sat_t;

  // atan(2^-i) in Q16 degrees.
  function automatic logic signed [25:0] atan_q16(input int unsigned i);
    logic signed [25:0] a;
    unique case (i)
      0: a = 26'sd2949120;
      1: a = 26'sd1740967;
      2: a = 26'sd919879;
      3: a = 26'sd466945;
      4: a = 26'sd234379;
      5: a = 26'sd117304;
      6: a = 26'sd58666;
      7: a = 26'sd29335;
      8: a = 26'sd14668;
      9: a = 26'sd7334;
      10: a = 26'sd3667;
      11: a = 26'sd1833;
      12: a = 26'sd917;
      13: a = 26'sd458;
      14: a = 26'sd229;
      15: a = 26'sd115;
      16: a = 26'sd57;
      17: a = 26'sd29;
      18: a = 26'sd14;
      19: a = 26'sd7;
      20: a = 26'sd4;
      21: a = 26'sd2;
      22: a = 26'sd1;
      default: a = 26'sd0;
    endcase
    return a;
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  // Q30 rescale of an unsigned product, rounded half up.
  function automatic logic [33:0] rnd30(input logic [63:0] p);
    logic [64:0] s;
    s = 65'(p) + (65'd1 << 29);
    return s[63:30];
  endfunction

  function automatic logic signed [39:0] sgn40(input logic [63:0] p, input logic neg);
    logic signed [39:0] r;
    r = $signed(40'(rnd30(p)));
    return neg ? -r : r;
  endfunction

  // Q16 degrees to Q9.7 degrees, rounded and clamped.
  function automatic logic signed [15:0] to_out(input logic signed [25:0] a);
    logic signed [26:0] s;
    logic signed [17:0] q;
    s = 27'(a) + 27'sd256;
    q = 18'(s >>> 9);
    if (q > 18'sd23040) return 16'sd23040;
    if (q < -18'sd23040) return -16'sd23040;
    return 16'(q);
  endfunction

endpackage

// ----- rtl/qte_if.sv -----
// Handshake channels of the quaternion to Euler angle core.
// Valid/ready with payload; no dependencies.
interface qte_quat_if;
  logic valid;
  logic ready;
  logic signed [31:0] quat_x;
  logic signed [31:0] quat_y;
  logic signed [31:0] quat_z;
  modport source(output valid, quat_x, quat_y, quat_z, input ready);
  modport sink(input valid, quat_x, quat_y, quat_z, output ready);
endinterface

interface qte_euler_if;
  logic valid;
  logic ready;
  logic signed [15:0] pitch_angle;
  logic signed [15:0] roll_angle;
  logic signed [15:0] yaw_angle;
  modport source(output valid, pitch_angle, roll_angle, yaw_angle, input ready);
  modport sink(input valid, pitch_angle, roll_angle, yaw_angle, output ready);
endinterface

// ----- rtl/quaternion_to_euler_angles_core.sv -----
// Quaternion (x, y, z in Q2.30) to Z-Y-X Euler angles in Q9.7 degrees.
// The pipeline runs through two 31-stage square roots and the CORDIC iteration stages.
// Throughput: one transaction per cycle; a stalled output freezes the whole pipeline.
// Reset: synchronous, active high; clears every valid bit, payload is not reset.
module quaternion_to_euler_angles_core #(
  parameter int CORDIC_STEPS = 20
) (
  input logic        clk,
  input logic        rst,
  qte_quat_if.sink   quat_in,
  qte_euler_if.source euler_out
);
  import qte_pkg::*;

  logic en;
  logic out_valid;
  logic signed [15:0] pitch_q, roll_q, yaw_q;

  assign en = !out_valid || euler_out.ready;
  assign quat_in.ready = en;

  // Stage 1: squares of the vector parts.
  logic v1;
  logic signed [31:0] x1, y1, z1;
  logic [63:0] px1, py1, pz1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= quat_in.valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      x1  <= quat_in.quat_x;
      y1  <= quat_in.quat_y;
      z1  <= quat_in.quat_z;
      px1 <= 64'(mag32(quat_in.quat_x)) * 64'(mag32(quat_in.quat_x));
      py1 <= 64'(mag32(quat_in.quat_y)) * 64'(mag32(quat_in.quat_y));
      pz1 <= 64'(mag32(quat_in.quat_z)) * 64'(mag32(quat_in.quat_z));
    end
  end

  // Stage 2: scalar square, clamped at zero.
  logic v2;
  qte_vec_side_t s2;
  logic [30:0] w0_2;
  logic [32:0] sx1, sy1, sz1;
  logic signed [35:0] w0_full;
  assign sx1 = 33'(rnd30(px1));
  assign sy1 = 33'(rnd30(py1));
  assign sz1 = 33'(rnd30(pz1));
  assign w0_full = $signed(36'd1 << 30) - $signed(36'(sx1)) - $signed(36'(sy1))
                   - $signed(36'(sz1));
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s2   <= '{x: x1, y: y1, z: z1, sx: sx1, sy: sy1, sz: sz1};
      w0_2 <= w0_full[35] ? 31'd0 : w0_full[30:0];
    end
  end

  logic v_w;
  logic [30:0] w_root;
  logic [$bits(qte_vec_side_t)-1:0] s_w_raw;
  qte_vec_side_t s_w;
  qte_sqrt #(.SW($bits(qte_vec_side_t))) u_sqrt_w (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v2), .in_val(w0_2), .in_side(s2),
    .out_valid(v_w), .out_root(w_root), .out_side(s_w_raw)
  );
  assign s_w = qte_vec_side_t'(s_w_raw);

  // Stage 3: cross products and cosine terms.
  logic v3;
  logic [63:0] p_wx, p_yz, p_wy, p_zx, p_wz, p_xy;
  logic n_wx, n_yz, n_wy, n_zx, n_wz, n_xy;
  logic signed [39:0] cosr3, cosy3;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v_w;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      p_wx  <= 64'(w_root) * 64'(mag32(s_w.x));
      p_yz  <= 64'(mag32(s_w.y)) * 64'(mag32(s_w.z));
      p_wy  <= 64'(w_root) * 64'(mag32(s_w.y));
      p_zx  <= 64'(mag32(s_w.z)) * 64'(mag32(s_w.x));
      p_wz  <= 64'(w_root) * 64'(mag32(s_w.z));
      p_xy  <= 64'(mag32(s_w.x)) * 64'(mag32(s_w.y));
      n_wx  <= s_w.x[31];
      n_yz  <= s_w.y[31] ^ s_w.z[31];
      n_wy  <= s_w.y[31];
      n_zx  <= s_w.z[31] ^ s_w.x[31];
      n_wz  <= s_w.z[31];
      n_xy  <= s_w.x[31] ^ s_w.y[31];
      cosr3 <= $signed(OneQ30 - ((40'(s_w.sx) + 40'(s_w.sy)) << 1));
      cosy3 <= $signed(OneQ30 - ((40'(s_w.sy) + 40'(s_w.sz)) << 1));
    end
  end

  // Stage 4: sine terms.
  logic v4;
  logic signed [39:0] sinr4, sinp4, siny4, cosr4, cosy4;
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sinr4 <= (sgn40(p_wx, n_wx) + sgn40(p_yz, n_yz)) <<< 1;
      sinp4 <= (sgn40(p_wy, n_wy) - sgn40(p_zx, n_zx)) <<< 1;
      siny4 <= (sgn40(p_wz, n_wz) + sgn40(p_xy, n_xy)) <<< 1;
      cosr4 <= cosr3;
      cosy4 <= cosy3;
    end
  end

  // Stage 5: pole detection and the square of the pitch sine.
  logic v5;
  qte_ang_side_t s5;
  logic [63:0] psq5;
  logic [39:0] sp_abs;
  logic [30:0] sp_m;
  assign sp_abs = sinp4[39] ? 40'(-sinp4) : 40'(sinp4);
  assign sp_m   = (sp_abs >= OneQ30) ? 31'(OneQ30) : sp_abs[30:0];
  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (en) v5 <= v4;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s5 <= '{sinr: sinr4, cosr: cosr4, siny: siny4, cosy: cosy4, sinp: sinp4,
              sat_pos: (sinp4 >= $signed(OneQ30)), sat_neg: (sinp4 <= -$signed(OneQ30))};
      psq5 <= 64'(sp_m) * 64'(sp_m);
    end
  end

  // Stage 6: squared pitch cosine.
  logic v6;
  qte_ang_side_t s6;
  logic [30:0] c2_6;
  logic [33:0] c2_full;
  assign c2_full = 34'(OneQ30) - rnd30(psq5);
  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else if (en) v6 <= v5;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s6   <= s5;
      c2_6 <= c2_full[30:0];
    end
  end

  logic v_c;
  logic [30:0] c_root;
  logic [$bits(qte_ang_side_t)-1:0] s_c_raw;
  qte_ang_side_t s_c;
  qte_sqrt #(.SW($bits(qte_ang_side_t))) u_sqrt_c (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v6), .in_val(c2_6), .in_side(s6),
    .out_valid(v_c), .out_root(c_root), .out_side(s_c_raw)
  );
  assign s_c = qte_ang_side_t'(s_c_raw);

  logic v_a;
  logic signed [25:0] a_pitch, a_roll, a_yaw;
  qte_sat_t sat_in, sat_out;
  assign sat_in = '{sat_pos: s_c.sat_pos, sat_neg: s_c.sat_neg};

  qte_cordic #(.STEPS(CORDIC_STEPS), .SW($bits(qte_sat_t))) u_cordic_pitch (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v_c), .in_y(s_c.sinp), .in_x($signed(40'(c_root))), .in_side(sat_in),
    .out_valid(v_a), .out_angle(a_pitch), .out_side(sat_out)
  );
  qte_cordic #(.STEPS(CORDIC_STEPS), .SW(1)) u_cordic_roll (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v_c), .in_y(s_c.sinr), .in_x(s_c.cosr), .in_side(1'b0),
    .out_valid(), .out_angle(a_roll), .out_side()
  );
  qte_cordic #(.STEPS(CORDIC_STEPS), .SW(1)) u_cordic_yaw (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v_c), .in_y(s_c.siny), .in_x(s_c.cosy), .in_side(1'b0),
    .out_valid(), .out_angle(a_yaw), .out_side()
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= v_a;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      priority if (sat_out.sat_pos) pitch_q <= 16'(OutLimit);
      else if (sat_out.sat_neg) pitch_q <= -16'(OutLimit);
      else pitch_q <= to_out(a_pitch);
      roll_q <= to_out(a_roll);
      yaw_q  <= to_out(a_yaw);
    end
  end

  assign euler_out.valid       = out_valid;
  assign euler_out.pitch_angle = pitch_q;
  assign euler_out.roll_angle  = roll_q;
  assign euler_out.yaw_angle   = yaw_q;
endmodule

// ----- rtl/qte_sqrt.sv -----
// Pipelined floor square root of (v << 30), one result bit per stage.
// Uses qte_pkg; every stage advances only while en is high.
module qte_sqrt #(
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [30:0]   in_val,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [30:0]   out_root,
  output logic [SW-1:0] out_side
);
  import qte_pkg::*;

  localparam int Steps = 31;

  logic          vld  [Steps+1];
  logic [61:0]   rem  [Steps+1];
  logic [61:0]   root [Steps+1];
  logic [SW-1:0] side [Steps+1];

  assign vld[0]  = in_valid;
  assign rem[0]  = {1'b0, in_val, 30'd0};
  assign root[0] = '0;
  assign side[0] = in_side;

  for (genvar k = 0; k < Steps; k++) begin : g_step
    localparam logic [61:0] Bit = 62'd1 << (2 * (Steps - 1 - k));
    logic [61:0] trial;
    logic        take;
    assign trial = root[k] + Bit;
    assign take  = rem[k] >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= take ? rem[k] - trial : rem[k];
        root[k+1] <= take ? (root[k] >> 1) + Bit : root[k] >> 1;
        side[k+1] <= side[k];
      end
    end
  end

  assign out_valid = vld[Steps];
  assign out_root  = root[Steps][30:0];
  assign out_side  = side[Steps];
endmodule

// ----- rtl/qte_cordic.sv -----
// Pipelined vectoring CORDIC giving atan2(y, x) in Q16 degrees.
// Uses qte_pkg; one quadrant stage and then one stage per iteration.
module qte_cordic #(
  parameter int STEPS = 20,
  parameter int SW = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic signed [39:0]  in_y,
  input  logic signed [39:0]  in_x,
  input  logic [SW-1:0]       in_side,
  output logic                out_valid,
  output logic signed [25:0]  out_angle,
  output logic [SW-1:0]       out_side
);
  import qte_pkg::*;

  logic                vld  [STEPS+1];
  logic signed [39:0]  xs   [STEPS+1];
  logic signed [39:0]  ys   [STEPS+1];
  logic signed [25:0]  ang  [STEPS+1];
  logic                zero [STEPS+1];
  logic [SW-1:0]       side [STEPS+1];

  // Vectors in the left half-plane are turned by a quarter first.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero[0] <= (in_x == 40'sd0) && (in_y == 40'sd0);
      side[0] <= in_side;
      if (!in_x[39]) begin
        xs[0]  <= in_x;
        ys[0]  <= in_y;
        ang[0] <= 26'sd0;
      end else if (!in_y[39]) begin
        xs[0]  <= in_y;
        ys[0]  <= -in_x;
        ang[0] <= Deg90Q16;
      end else begin
        xs[0]  <= -in_y;
        ys[0]  <= in_x;
        ang[0] <= -Deg90Q16;
      end
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_iter
    logic signed [39:0] dx;
    logic signed [39:0] dy;
    assign dx = ys[i] >>> i;
    assign dy = xs[i] >>> i;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        zero[i+1] <= zero[i];
        side[i+1] <= side[i];
        if (!ys[i][39]) begin
          xs[i+1]  <= xs[i] + dx;
          ys[i+1]  <= ys[i] - dy;
          ang[i+1] <= ang[i] + atan_q16(i);
        end else begin
          xs[i+1]  <= xs[i] - dx;
          ys[i+1]  <= ys[i] + dy;
          ang[i+1] <= ang[i] - atan_q16(i);
        end
      end
    end
  end

  assign out_valid = vld[STEPS];
  assign out_angle = zero[STEPS] ? 26'sd0 : ang[STEPS];
  assign out_side  = side[STEPS];
endmodule

// ----- rtl/qte_checker.sv -----
// Port-level assertions for quaternion_to_euler_angles_core.
// Bound to the top level below; depends on nothing else.
module qte_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] pitch,
  input logic [15:0] roll,
  input logic [15:0] yaw
);
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled although output can move");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(pitch) && $stable(roll)
                                   && $stable(yaw)))
    else $error("stalled output transaction changed");

  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($signed(pitch) >= -16'sd23040 && $signed(pitch) <= 16'sd23040))
    else $error("pitch out of range");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($signed(roll) >= -16'sd23040 && $signed(roll) <= 16'sd23040
                   && $signed(yaw) >= -16'sd23040 && $signed(yaw) <= 16'sd23040))
    else $error("roll or yaw out of range");
endmodule

bind quaternion_to_euler_angles_core qte_checker u_qte_checker (
  .clk(clk),
  .rst(rst),
  .in_ready(quat_in.ready),
  .out_valid(euler_out.valid),
  .out_ready(euler_out.ready),
  .pitch(euler_out.pitch_angle),
  .roll(euler_out.roll_angle),
  .yaw(euler_out.yaw_angle)
);

// ----- bench/tb.sv -----
// Testbench for quaternion_to_euler_angles_core: drives quaternion transactions,
// predicts the Euler angles in fixed point and checks every result in order.
// Depends on qte_pkg, qte_if.sv and the core RTL.
`timescale 1ns / 100ps

class euler_scoreboard;
  typedef struct {
    logic signed [15:0] pitch;
    logic signed [15:0] roll;
    logic signed [15:0] yaw;
  } angles_t;

  localparam longint OneQ30 = 64'sd1 << 30;
  localparam longint Deg90Q16 = 64'sd90 <<< 16;
  localparam longint AtanQ16[0:22] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1};

  angles_t expected_angles[$];
  int errors;
  int cordic_steps;

  function new(int steps);
    errors = 0;
    cordic_steps = steps;
  endfunction

  // Q30 product of magnitudes, rounded half away from zero.
  function longint mul_q30(longint a, longint b);
    longint unsigned ma, mb, p;
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    p = (ma * mb + (64'd1 << 29)) >> 30;
    return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
  endfunction

  function longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Four-quadrant arctangent in Q16 degrees.
  function longint atan2_q16(longint y, longint x);
    longint ang, t, dx, dy;
    ang = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;
        y = -t;
        ang = Deg90Q16;
      end else begin
        x = -y;
        y = t;
        ang = -Deg90Q16;
      end
    end
    for (int i = 0; i < cordic_steps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx;
        y -= dy;
        ang += (i < 23) ? AtanQ16[i] : 0;
      end else begin
        x -= dx;
        y += dy;
        ang -= (i < 23) ? AtanQ16[i] : 0;
      end
    end
    return ang;
  endfunction

  function logic signed [15:0] deg_q97(longint a);
    longint v;
    v = (a + 256) >>> 9;
    if (v > 23040) v = 23040;
    if (v < -23040) v = -23040;
    return 16'(v);
  endfunction

  function void note_quaternion(logic [31:0] qx, logic [31:0] qy, logic [31:0] qz);
    longint x, y, z, sx, sy, sz, w0, w, sinr, cosr, sinp, siny, cosy, c2;
    angles_t e;
    x = longint'($signed(qx));
    y = longint'($signed(qy));
    z = longint'($signed(qz));
    sx = mul_q30(x, x);
    sy = mul_q30(y, y);
    sz = mul_q30(z, z);
    w0 = OneQ30 - sx - sy - sz;
    if (w0 < 0) w0 = 0;
    w = longint'(floor_sqrt(longint'(w0) << 30));
    sinr = 2 * (mul_q30(w, x) + mul_q30(y, z));
    cosr = OneQ30 - 2 * (sx + sy);
    sinp = 2 * (mul_q30(w, y) - mul_q30(z, x));
    siny = 2 * (mul_q30(w, z) + mul_q30(x, y));
    cosy = OneQ30 - 2 * (sy + sz);
    if (sinp >= OneQ30) begin
      e.pitch = 16'sd23040;
    end else if (sinp <= -OneQ30) begin
      e.pitch = -16'sd23040;
    end else begin
      c2 = OneQ30 - mul_q30(sinp, sinp);
      if (c2 < 0) c2 = 0;
      e.pitch = deg_q97(atan2_q16(sinp, longint'(floor_sqrt(c2 << 30))));
    end
    e.roll = deg_q97(atan2_q16(sinr, cosr));
    e.yaw = deg_q97(atan2_q16(siny, cosy));
    expected_angles.push_back(e);
  endfunction

  task report(string what);
    $display("mismatch at %0t: %s", $time, what);
    errors++;
  endtask

  task check_angles(logic signed [15:0] pitch, logic signed [15:0] roll,
                    logic signed [15:0] yaw);
    angles_t e;
    if (expected_angles.size() == 0) begin
      report($sformatf("unexpected result %0d %0d %0d", pitch, roll, yaw));
      return;
    end
    e = expected_angles.pop_front();
    if (pitch !== e.pitch) report($sformatf("pitch %0d, want %0d", pitch, e.pitch));
    if (roll !== e.roll) report($sformatf("roll %0d, want %0d", roll, e.roll));
    if (yaw !== e.yaw) report($sformatf("yaw %0d, want %0d", yaw, e.yaw));
  endtask
endclass

module tb;
  import qte_pkg::*;

  localparam int Steps = 20;
  localparam int RandomItems = 1530;
  localparam logic [31:0] HalfRoot = 32'd759250125;  // sqrt(0.5) in Q2.30

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic long_hold = 1'b0;

  qte_quat_if quat_ch();
  qte_euler_if euler_ch();

  quaternion_to_euler_angles_core #(.CORDIC_STEPS(Steps)) dut (
    .clk(clk),
    .rst(rst),
    .quat_in(quat_ch.sink),
    .euler_out(euler_ch.source)
  );

  euler_scoreboard angle_board = new(Steps);

  always #2 clk = ~clk;

  initial begin
    #2ms;
    $display("tb failed");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_quaternion(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    @(negedge clk);
    quat_ch.valid <= 1'b1;
    quat_ch.quat_x <= x;
    quat_ch.quat_y <= y;
    quat_ch.quat_z <= z;
    do @(posedge clk); while (!quat_ch.ready);
    angle_board.note_quaternion(x, y, z);
  endtask

  task automatic idle_input(int gap);
    if (gap > 0) begin
      @(negedge clk);
      quat_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    while (angle_board.expected_angles.size() != 0) @(posedge clk);
  endtask

  // Random quaternion: in 45 of 100 draws unit length with one part rebuilt,
  // in 40 well inside the unit ball, in the rest raw bit patterns.
  task automatic send_random();
    int r;
    logic [31:0] x, y, z;
    longint sx, rest;
    r = $urandom_range(0, 99);
    x = $urandom;
    y = $urandom;
    z = $urandom;
    if (r < 45) begin
      x = 32'($signed(x) >>> 2);
      y = 32'($signed(y) >>> 3);
      sx = angle_board.mul_q30($signed(x), $signed(x))
         + angle_board.mul_q30($signed(y), $signed(y));
      rest = (64'sd1 << 30) - sx;
      if (rest < 0) rest = 0;
      z = 32'(angle_board.floor_sqrt(rest << 30));
      if ($urandom_range(0, 1)) z = -z;
      if (r < 15) {x, y, z} = {z, x, y};
    end else if (r < 85) begin
      x = 32'($signed(x) >>> 3);
      y = 32'($signed(y) >>> 3);
      z = 32'($signed(z) >>> 3);
    end
    send_quaternion(x, y, z);
    idle_input(pick_gap());
  endtask

  // Result side: random stalls, and one long hold on request.
  initial begin
    euler_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        euler_ch.ready <= 1'b0;
        repeat (400) @(negedge clk);
        long_hold = 1'b0;
      end else if ($urandom_range(0, 99) < 25) begin
        euler_ch.ready <= 1'b0;
        repeat (pick_gap()) @(negedge clk);
      end else begin
        euler_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && euler_ch.valid && euler_ch.ready)
      angle_board.check_angles(euler_ch.pitch_angle, euler_ch.roll_angle,
                               euler_ch.yaw_angle);
  end

  initial begin
    int wait_cycles;
    quat_ch.valid = 1'b0;
    quat_ch.quat_x = '0;
    quat_ch.quat_y = '0;
    quat_ch.quat_z = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed corners: zero vector, unit axes, poles, extremes of the words.
    send_quaternion(32'd0, 32'd0, 32'd0);
    send_quaternion(32'h4000_0000, 32'd0, 32'd0);
    send_quaternion(32'd0, 32'h4000_0000, 32'd0);
    send_quaternion(32'd0, 32'd0, 32'h4000_0000);
    send_quaternion(32'hC000_0000, 32'd0, 32'd0);
    send_quaternion(32'd0, 32'hC000_0000, 32'd0);
    send_quaternion(32'd0, 32'd0, 32'hC000_0000);
    send_quaternion(32'd0, HalfRoot, 32'd0);
    send_quaternion(32'd0, -HalfRoot, 32'd0);
    send_quaternion(HalfRoot, 32'd0, -HalfRoot);
    send_quaternion(-HalfRoot, 32'd0, HalfRoot);
    send_quaternion(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_quaternion(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_quaternion(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_quaternion(32'h8000_0000, 32'h7FFF_FFFF, 32'd0);
    send_quaternion(32'd0, 32'd1, 32'hFFFF_FFFF);
    send_quaternion(32'h2000_0000, 32'h2000_0000, 32'h2000_0000);
    send_quaternion(32'd0, 32'h2000_0000, 32'hE000_0000);
    send_quaternion(32'h3000_0000, 32'hD000_0000, 32'h1000_0000);
    send_quaternion(32'hE000_0000, 32'hE000_0000, 32'hE000_0000);
    idle_input(1);

    // The sender waits until every result is back.
    wait_drained();

    for (int i = 0; i < RandomItems; i++) begin
      if (i == 300) long_hold = 1'b1;
      if (i == 900) begin
        idle_input(1);
        wait_drained();
      end
      send_random();
    end
    idle_input(1);

    wait_drained();
    wait_cycles = 0;
    while (wait_cycles < 150) begin
      @(posedge clk);
      wait_cycles++;
    end
    if (angle_board.errors == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end
endmodule
